// ===== src/atrp_pkg.sv =====
package atrp_pkg;

  // Field widths.
  localparam int IN_W    = 16;
  localparam int ROLL_W  = 17;
  localparam int PITCH_W = 16;

  // Internal widths: squares, root, vector lanes and angle accumulator.
  localparam int SQ_W   = 32;
  localparam int ROOT_W = 24;
  localparam int REM_W  = 26;
  localparam int VEC_W  = 27;
  localparam int ACC_W  = 27;

  // Angle constants, in 1/65536 degree.
  localparam int TABLE_LEN       = 24;
  localparam int ANGLE_STEPS_DEF = 16;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 27'sd5898674;

  // Rotation angle of micro-rotation i, round(atan(2^-i) * 57.3 * 65536).
  function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = 27'sd2949337;
      1:  v = 27'sd1741095;
      2:  v = 27'sd919947;
      3:  v = 27'sd466979;
      4:  v = 27'sd234396;
      5:  v = 27'sd117312;
      6:  v = 27'sd58670;
      7:  v = 27'sd29337;
      8:  v = 27'sd14669;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1834;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/accel_tilt_roll_pitch_top.sv =====
// Roll and pitch from one three-axis acceleration sample, fully pipelined.
// Stages, in order: one input stage, square, sum, 24 root stages, fold stage,
// STEPS CORDIC stages (ANGLE_STEPS capped at TABLE_LEN), then the output register.
// Throughput: one sample per cycle; busy is always low since the receiver cannot stall.
// Reset (synchronous, active low) clears all stage valid bits; data registers are not reset.
module accel_tilt_roll_pitch_top #(
  parameter int ANGLE_STEPS = atrp_pkg::ANGLE_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [atrp_pkg::IN_W-1:0]    in_accel_x,
  input  logic signed [atrp_pkg::IN_W-1:0]    in_accel_y,
  input  logic signed [atrp_pkg::IN_W-1:0]    in_accel_z,
  output logic                                out_valid,
  output logic signed [atrp_pkg::ROLL_W-1:0]  out_roll_angle,
  output logic signed [atrp_pkg::PITCH_W-1:0] out_pitch_angle
);

  localparam int IN_W    = atrp_pkg::IN_W;
  localparam int SQ_W    = atrp_pkg::SQ_W;
  localparam int ROOT_W  = atrp_pkg::ROOT_W;
  localparam int REM_W   = atrp_pkg::REM_W;
  localparam int VEC_W   = atrp_pkg::VEC_W;
  localparam int ACC_W   = atrp_pkg::ACC_W;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int STEPS   = (ANGLE_STEPS > atrp_pkg::TABLE_LEN) ?
                           atrp_pkg::TABLE_LEN : ANGLE_STEPS;
  localparam int FIN_W   = ACC_W - 8;

  assign busy = 1'b0;

  // Input stage.
  logic                   in_vld_r;
  logic signed [IN_W-1:0] x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    x0_r <= in_accel_x;
    y0_r <= in_accel_y;
    z0_r <= in_accel_z;
  end

  // Square stage.
  logic                   mul_vld_r;
  logic signed [IN_W-1:0] x1_r, y1_r, z1_r;
  logic signed [SQ_W-1:0] yy_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= in_vld_r;
    end
    x1_r <= x0_r;
    y1_r <= y0_r;
    z1_r <= z0_r;
    yy_r <= SQ_W'(y0_r) * SQ_W'(y0_r);
    zz_r <= SQ_W'(z0_r) * SQ_W'(z0_r);
  end

  // Sum stage: the radicand is (y*y + z*z) * 65536.
  logic                   sq_vld [0:ROOT_W];
  logic signed [IN_W-1:0] sx [0:ROOT_W];
  logic signed [IN_W-1:0] sy [0:ROOT_W];
  logic signed [IN_W-1:0] sz [0:ROOT_W];
  logic [RAD_W-1:0]       srad [0:ROOT_W];
  logic [REM_W-1:0]       srem [0:ROOT_W];
  logic [ROOT_W-1:0]      sroot [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= mul_vld_r;
    end
    sx[0]    <= x1_r;
    sy[0]    <= y1_r;
    sz[0]    <= z1_r;
    srad[0]  <= {SQ_W'(yy_r + zz_r), 16'b0};
    srem[0]  <= '0;
    sroot[0] <= '0;
  end

  // Square root, one result bit per stage, radicand consumed two bits at a time.
  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] sub;
      logic             fits;

      always_comb begin
        trial = {srem[k], srad[k][RAD_W-1 -: 2]};
        sub   = trial - (REM_W+2)'({sroot[k], 2'b01});
        fits  = trial >= (REM_W+2)'({sroot[k], 2'b01});
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_vld[k+1] <= 1'b0;
        end else begin
          sq_vld[k+1] <= sq_vld[k];
        end
        sx[k+1]    <= sx[k];
        sy[k+1]    <= sy[k];
        sz[k+1]    <= sz[k];
        srad[k+1]  <= {srad[k][RAD_W-3:0], 2'b00};
        srem[k+1]  <= fits ? sub[REM_W-1:0] : trial[REM_W-1:0];
        sroot[k+1] <= {sroot[k][ROOT_W-2:0], fits};
      end
    end
  endgenerate

  // Fold stage: roll vector (z, y) and pitch vector (r, -x), scaled by 256,
  // turned by a quarter turn when the first component is negative.
  logic                    c_vld [0:STEPS];
  logic signed [VEC_W-1:0] ra [0:STEPS];
  logic signed [VEC_W-1:0] rb [0:STEPS];
  logic signed [ACC_W-1:0] racc [0:STEPS];
  logic signed [VEC_W-1:0] pa [0:STEPS];
  logic signed [VEC_W-1:0] pb [0:STEPS];
  logic signed [ACC_W-1:0] pacc [0:STEPS];

  logic signed [VEC_W-1:0] roll_a, roll_b, pit_a, pit_b;

  always_comb begin
    roll_a = VEC_W'(sz[ROOT_W]) <<< 8;
    roll_b = VEC_W'(sy[ROOT_W]) <<< 8;
    pit_a  = VEC_W'({1'b0, sroot[ROOT_W]});
    pit_b  = -(VEC_W'(sx[ROOT_W]) <<< 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld[0] <= 1'b0;
    end else begin
      c_vld[0] <= sq_vld[ROOT_W];
    end
    if (roll_a < 0) begin
      if (roll_b >= 0) begin
        ra[0]   <= roll_b;
        rb[0]   <= -roll_a;
        racc[0] <= atrp_pkg::QUARTER_TURN;
      end else begin
        ra[0]   <= -roll_b;
        rb[0]   <= roll_a;
        racc[0] <= -atrp_pkg::QUARTER_TURN;
      end
    end else begin
      ra[0]   <= roll_a;
      rb[0]   <= roll_b;
      racc[0] <= '0;
    end
    if (pit_a < 0) begin
      if (pit_b >= 0) begin
        pa[0]   <= pit_b;
        pb[0]   <= -pit_a;
        pacc[0] <= atrp_pkg::QUARTER_TURN;
      end else begin
        pa[0]   <= -pit_b;
        pb[0]   <= pit_a;
        pacc[0] <= -atrp_pkg::QUARTER_TURN;
      end
    end else begin
      pa[0]   <= pit_a;
      pb[0]   <= pit_b;
      pacc[0] <= '0;
    end
  end

  // CORDIC vectoring, one micro-rotation per stage for both lanes.
  genvar i;
  generate
    for (i = 0; i < STEPS; i++) begin : g_cordic
      localparam logic signed [ACC_W-1:0] ANG = atrp_pkg::atan_entry(i);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          c_vld[i+1] <= 1'b0;
        end else begin
          c_vld[i+1] <= c_vld[i];
        end
        if (rb[i] > 0) begin
          ra[i+1]   <= ra[i] + (rb[i] >>> i);
          rb[i+1]   <= rb[i] - (ra[i] >>> i);
          racc[i+1] <= racc[i] + ANG;
        end else if (rb[i] < 0) begin
          ra[i+1]   <= ra[i] - (rb[i] >>> i);
          rb[i+1]   <= rb[i] + (ra[i] >>> i);
          racc[i+1] <= racc[i] - ANG;
        end else begin
          ra[i+1]   <= ra[i];
          rb[i+1]   <= rb[i];
          racc[i+1] <= racc[i];
        end
        if (pb[i] > 0) begin
          pa[i+1]   <= pa[i] + (pb[i] >>> i);
          pb[i+1]   <= pb[i] - (pa[i] >>> i);
          pacc[i+1] <= pacc[i] + ANG;
        end else if (pb[i] < 0) begin
          pa[i+1]   <= pa[i] - (pb[i] >>> i);
          pb[i+1]   <= pb[i] + (pa[i] >>> i);
          pacc[i+1] <= pacc[i] - ANG;
        end else begin
          pa[i+1]   <= pa[i];
          pb[i+1]   <= pb[i];
          pacc[i+1] <= pacc[i];
        end
      end
    end
  endgenerate

  // Output stage: round half up to 1/256 degree and saturate to the field width.
  logic signed [ACC_W-1:0]                roll_sum, pit_sum;
  logic signed [FIN_W-1:0]                roll_fin, pit_fin;
  logic signed [atrp_pkg::ROLL_W-1:0]     roll_sat;
  logic signed [atrp_pkg::PITCH_W-1:0]    pit_sat;
  logic                                   out_valid_r;
  logic signed [atrp_pkg::ROLL_W-1:0]     roll_r;
  logic signed [atrp_pkg::PITCH_W-1:0]    pitch_r;

  always_comb begin
    roll_sum = racc[STEPS] + ACC_W'(128);
    pit_sum  = pacc[STEPS] + ACC_W'(128);
    roll_fin = FIN_W'(roll_sum >>> 8);
    pit_fin  = FIN_W'(pit_sum >>> 8);
    if (roll_fin > FIN_W'(65535)) begin
      roll_sat = 17'sd65535;
    end else if (roll_fin < -FIN_W'(65536)) begin
      roll_sat = -17'sd65536;
    end else begin
      roll_sat = atrp_pkg::ROLL_W'(roll_fin);
    end
    if (pit_fin > FIN_W'(32767)) begin
      pit_sat = 16'sd32767;
    end else if (pit_fin < -FIN_W'(32768)) begin
      pit_sat = -16'sd32768;
    end else begin
      pit_sat = atrp_pkg::PITCH_W'(pit_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld[STEPS];
    end
    roll_r  <= roll_sat;
    pitch_r <= pit_sat;
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;

  // The root leaving the last stage is the floor square root of its radicand.
  logic [RAD_W:0] root_sq, root_up_sq, rad_chk;
  always_comb begin
    root_sq    = (RAD_W+1)'(sroot[ROOT_W]) * (RAD_W+1)'(sroot[ROOT_W]);
    root_up_sq = ((RAD_W+1)'(sroot[ROOT_W]) + 1'b1) * ((RAD_W+1)'(sroot[ROOT_W]) + 1'b1);
    rad_chk    = (RAD_W+1)'({SQ_W'(SQ_W'(sy[ROOT_W]) * SQ_W'(sy[ROOT_W]) +
                                   SQ_W'(sz[ROOT_W]) * SQ_W'(sz[ROOT_W])), 16'b0});
  end

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld[ROOT_W] |-> (root_sq <= rad_chk) && (root_up_sq > rad_chk))
    else $error("square root stage gave a wrong root");

  a_no_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised on a non-stalling pipeline");

  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  a_zero_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld[0] && pb[0] == 0) |-> ##(STEPS+1) (out_pitch_angle == 0))
    else $error("pitch of a sample with zero x is not zero");

endmodule
